### rtl/ckl_pkg.sv
package ckl_pkg;

  localparam int CAPACITY_DEF = 10;

  localparam int NAME_BYTES = 29;
  localparam int KIND_BYTES = 19;
  localparam int NAME_BITS  = 8 * NAME_BYTES;
  localparam int KIND_BITS  = 8 * KIND_BYTES;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;
  localparam logic [1:0] REQ_LIST   = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;
  localparam logic [2:0] ST_LISTED   = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [63:0]        name_a;
    logic [63:0]        name_b;
    logic [63:0]        name_c;
    logic [39:0]        name_d;
    logic [63:0]        kind_a;
    logic [63:0]        kind_b;
    logic [23:0]        kind_c;
    logic signed [31:0] amount;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [63:0]        out_name_a;
    logic [63:0]        out_name_b;
    logic [63:0]        out_name_c;
    logic [39:0]        out_name_d;
    logic [63:0]        out_kind_a;
    logic [63:0]        out_kind_b;
    logic [23:0]        out_kind_c;
    logic signed [31:0] out_amount;
    logic               last;
  } out_res_t;

  // One table entry; byte 0 of each string sits in the lowest bits.
  typedef struct packed {
    logic [NAME_BITS-1:0] name;
    logic [KIND_BITS-1:0] kind;
    logic signed [31:0]   amount;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic compact;
  } cell_ctrl_t;

  // Every byte after the first NUL is forced to zero.
  function automatic logic [NAME_BITS-1:0] clean_name(input logic [NAME_BITS-1:0] v);
    logic [NAME_BITS-1:0] res;
    logic                 ended;
    logic [7:0]           b;
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      b = v[8*k +: 8];
      if (ended) b = 8'h00;
      if (b == 8'h00) ended = 1'b1;
      res[8*k +: 8] = b;
    end
    return res;
  endfunction

  function automatic logic [KIND_BITS-1:0] clean_kind(input logic [KIND_BITS-1:0] v);
    logic [KIND_BITS-1:0] res;
    logic                 ended;
    logic [7:0]           b;
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < KIND_BYTES; k++) begin
      b = v[8*k +: 8];
      if (ended) b = 8'h00;
      if (b == 8'h00) ended = 1'b1;
      res[8*k +: 8] = b;
    end
    return res;
  endfunction

endpackage

### rtl/ckl_cell.sv
module ckl_cell #(
  parameter int CNT_W = 4,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  ckl_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    tgt,
  input  ckl_pkg::entry_t     load_d,
  input  ckl_pkg::entry_t     nbr_d,
  output ckl_pkg::entry_t     q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  ckl_pkg::entry_t q_r;
  logic            load_en;
  logic            shift_en;

  // A cell takes its neighbor's entry on a rotate step, or when a removal
  // closes the gap at or below it.
  assign load_en  = ctrl.load && (tgt == MY_IDX);
  assign shift_en = ctrl.rotate || (ctrl.compact && (MY_IDX >= tgt));

  always_ff @(posedge clk) begin
    if (load_en) begin
      q_r <= load_d;
    end else if (shift_en) begin
      q_r <= nbr_d;
    end
  end

  assign q = q_r;

endmodule

### rtl/compacting_keyed_list_core.sv
// Channel   Ports                   Handshake
// request   start, busy, in_req     taken at a clock edge with start high, busy low
// result    out_strobe, out_res     single-cycle strobe per result, no back pressure
//
// Insert, and remove or list on an empty table, finish in the dispatch state.
// Remove, search and list rotate the whole cell chain once past the head
// cell, then finish in a closing state.
// Results leave through an output register, in the cycle after they are formed.
// Reset (synchronous, active low) empties the table; entry contents are
// not cleared.
module compacting_keyed_list_core #(
  parameter int CAPACITY = ckl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ckl_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output ckl_pkg::out_res_t out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  found_idx_r, found_idx_nxt;
  logic [1:0]        req_type_r;
  ckl_pkg::entry_t   req_entry_r, req_entry_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  ckl_pkg::out_res_t out_res_r, out_res_nxt;

  ckl_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]    tgt;
  ckl_pkg::entry_t     cell_q [CAPACITY];
  ckl_pkg::entry_t     head;
  logic                in_range;
  logic                head_hit;
  logic [CNT_W:0]      step_slot;
  logic [CNT_W:0]      found_slot;

  function automatic ckl_pkg::out_res_t make_res(input logic [2:0]      status,
                                                 input logic [CNT_W:0]  slot,
                                                 input ckl_pkg::entry_t e,
                                                 input logic            with_entry,
                                                 input logic            last);
    ckl_pkg::out_res_t r;
    r        = '0;
    r.status = status;
    r.slot   = 4'(slot);
    r.last   = last;
    if (with_entry) begin
      r.out_name_a = e.name[63:0];
      r.out_name_b = e.name[127:64];
      r.out_name_c = e.name[191:128];
      r.out_name_d = e.name[231:192];
      r.out_kind_a = e.kind[63:0];
      r.out_kind_b = e.kind[127:64];
      r.out_kind_c = e.kind[151:128];
      r.out_amount = e.amount;
    end
    return r;
  endfunction

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ckl_cell #(
      .CNT_W(CNT_W),
      .IDX  (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .tgt   (tgt),
      .load_d(req_entry_r),
      .nbr_d (cell_q[(i + 1) % CAPACITY]),
      .q     (cell_q[i])
    );
  end

  assign head       = cell_q[0];
  assign in_range   = step_r < count_r;
  assign head_hit   = in_range && !found_r && (head.name == req_entry_r.name);
  assign step_slot  = {1'b0, step_r} + 1'b1;
  assign found_slot = {1'b0, found_idx_r} + 1'b1;

  always_comb begin
    req_entry_nxt.name   = ckl_pkg::clean_name({in_req.name_d, in_req.name_c,
                                                in_req.name_b, in_req.name_a});
    req_entry_nxt.kind   = ckl_pkg::clean_kind({in_req.kind_c, in_req.kind_b,
                                                in_req.kind_a});
    req_entry_nxt.amount = in_req.amount;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    ctrl           = '0;
    tgt            = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISP;
      end
      S_DISP: begin
        step_nxt  = '0;
        found_nxt = 1'b0;
        unique case (req_type_r)
          ckl_pkg::REQ_INSERT: begin
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
            if (count_r >= CNT_W'(CAPACITY)) begin
              out_res_nxt = make_res(ckl_pkg::ST_FULL, '0, head, 1'b0, 1'b1);
            end else begin
              ctrl.load   = 1'b1;
              count_nxt   = CNT_W'(count_r + 1'b1);
              out_res_nxt = make_res(ckl_pkg::ST_INSERTED, '0, head, 1'b0, 1'b1);
            end
          end
          ckl_pkg::REQ_SEARCH: begin
            state_nxt = S_SCAN;
          end
          default: begin
            if (count_r == '0) begin
              out_strobe_nxt = 1'b1;
              out_res_nxt    = make_res(ckl_pkg::ST_EMPTY, '0, head, 1'b0, 1'b1);
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        // The chain turns one place per cycle; after CAPACITY steps every
        // entry is back where it started.
        ctrl.rotate = 1'b1;
        step_nxt    = CNT_W'(step_r + 1'b1);
        if (req_type_r == ckl_pkg::REQ_LIST) begin
          if (in_range) begin
            out_strobe_nxt = 1'b1;
            out_res_nxt    = make_res(ckl_pkg::ST_LISTED, step_slot, head, 1'b1,
                                      step_slot == {1'b0, count_r});
          end
        end else if (head_hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = step_r;
          // The matching entry is parked in the output register until the
          // walk ends.
          out_res_nxt   = make_res(ckl_pkg::ST_FOUND, step_slot, head, 1'b1, 1'b1);
        end
        if (step_r == CNT_W'(CAPACITY - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        if (req_type_r != ckl_pkg::REQ_LIST) begin
          out_strobe_nxt = 1'b1;
          if (!found_r) begin
            out_res_nxt = make_res(ckl_pkg::ST_NOTFOUND, '0, head, 1'b0, 1'b1);
          end else if (req_type_r == ckl_pkg::REQ_SEARCH) begin
            out_res_nxt = make_res(ckl_pkg::ST_FOUND, found_slot, head, 1'b0, 1'b1);
            out_res_nxt.out_name_a = out_res_r.out_name_a;
            out_res_nxt.out_name_b = out_res_r.out_name_b;
            out_res_nxt.out_name_c = out_res_r.out_name_c;
            out_res_nxt.out_name_d = out_res_r.out_name_d;
            out_res_nxt.out_kind_a = out_res_r.out_kind_a;
            out_res_nxt.out_kind_b = out_res_r.out_kind_b;
            out_res_nxt.out_kind_c = out_res_r.out_kind_c;
            out_res_nxt.out_amount = out_res_r.out_amount;
          end else begin
            ctrl.compact = 1'b1;
            tgt          = found_idx_r;
            count_nxt    = CNT_W'(count_r - 1'b1);
            out_res_nxt  = make_res(ckl_pkg::ST_REMOVED, '0, head, 1'b0, 1'b1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      step_r       <= '0;
      found_r      <= 1'b0;
      found_idx_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      found_r      <= found_nxt;
      found_idx_r  <= found_idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (start && (state_r == S_IDLE)) begin
      req_type_r  <= in_req.req_type;
      req_entry_r <= req_entry_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

### rtl/ckl_checker.sv
module ckl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input ckl_pkg::out_res_t out_res
);

  logic plain_status;

  assign plain_status = (out_res.status == ckl_pkg::ST_INSERTED) ||
                        (out_res.status == ckl_pkg::ST_FULL) ||
                        (out_res.status == ckl_pkg::ST_REMOVED) ||
                        (out_res.status == ckl_pkg::ST_EMPTY) ||
                        (out_res.status == ckl_pkg::ST_NOTFOUND);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (!busy && !out_strobe))
    else $error("block not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Only listed entries can be followed by more results of the same request.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.status != ckl_pkg::ST_LISTED)) |-> out_res.last)
    else $error("single result without last");

  a_plain_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && plain_status) |-> ((out_res.slot == '0) && (out_res.out_amount == '0)))
    else $error("status result carries entry data");

  a_no_idle_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.last) |-> busy)
    else $error("partial listing while idle");

endmodule

bind compacting_keyed_list_core ckl_checker u_ckl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_res   (out_res)
);

### tb/compacting_keyed_list_core_tb.sv
`timescale 1ns / 1ps

module compacting_keyed_list_core_tb;
  import ckl_pkg::*;

  localparam int DEPTH      = CAPACITY_DEF;
  localparam int TEXT_BITS  = 256;
  localparam int POOL_SIZE  = 12;
  localparam int QUIET_MAX  = 4000;
  localparam int DRAIN_WAIT = DEPTH + 8;

  // Shadow copy of the table; every accepted request queues the results it must cause.
  class table_tracker;
    logic [NAME_BITS-1:0] names [DEPTH];
    logic [KIND_BITS-1:0] kinds [DEPTH];
    logic signed [31:0]   amounts [DEPTH];
    int                   count;
    out_res_t             due_results [$];
    int                   errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Zero every byte past the first NUL and every byte beyond nbytes.
    function logic [TEXT_BITS-1:0] strip_text(logic [TEXT_BITS-1:0] v, int nbytes);
      logic [TEXT_BITS-1:0] res;
      bit                   ended;
      res   = '0;
      ended = 0;
      for (int k = 0; k < nbytes; k++) begin
        if (!ended && v[8*k +: 8] == 8'h00) ended = 1;
        if (!ended) res[8*k +: 8] = v[8*k +: 8];
      end
      return res;
    endfunction

    function int locate(logic [NAME_BITS-1:0] key);
      for (int i = 0; i < count; i++) begin
        if (names[i] == key) return i;
      end
      return -1;
    endfunction

    function out_res_t make_result(logic [2:0] status, logic [3:0] slot, int idx, bit last);
      out_res_t r;
      r        = '0;
      r.status = status;
      r.slot   = slot;
      if (idx >= 0) begin
        r.out_name_a = names[idx][63:0];
        r.out_name_b = names[idx][127:64];
        r.out_name_c = names[idx][191:128];
        r.out_name_d = names[idx][231:192];
        r.out_kind_a = kinds[idx][63:0];
        r.out_kind_b = kinds[idx][127:64];
        r.out_kind_c = kinds[idx][151:128];
        r.out_amount = amounts[idx];
      end
      r.last = last;
      return r;
    endfunction

    function void take_request(in_req_t req);
      logic [NAME_BITS-1:0] key;
      int                   idx;
      key = NAME_BITS'(strip_text(TEXT_BITS'({req.name_d, req.name_c, req.name_b, req.name_a}),
                                  NAME_BYTES));
      case (req.req_type)
        REQ_INSERT: begin
          if (count >= DEPTH) begin
            due_results.push_back(make_result(ST_FULL, 4'd0, -1, 1));
          end else begin
            names[count]   = key;
            kinds[count]   = KIND_BITS'(strip_text(TEXT_BITS'({req.kind_c, req.kind_b,
                                                              req.kind_a}), KIND_BYTES));
            amounts[count] = req.amount;
            count++;
            due_results.push_back(make_result(ST_INSERTED, 4'd0, -1, 1));
          end
        end
        REQ_REMOVE: begin
          idx = locate(key);
          if (count == 0) begin
            due_results.push_back(make_result(ST_EMPTY, 4'd0, -1, 1));
          end else if (idx < 0) begin
            due_results.push_back(make_result(ST_NOTFOUND, 4'd0, -1, 1));
          end else begin
            for (int i = idx; i + 1 < count; i++) begin
              names[i]   = names[i+1];
              kinds[i]   = kinds[i+1];
              amounts[i] = amounts[i+1];
            end
            count--;
            due_results.push_back(make_result(ST_REMOVED, 4'd0, -1, 1));
          end
        end
        REQ_SEARCH: begin
          idx = locate(key);
          if (idx < 0) due_results.push_back(make_result(ST_NOTFOUND, 4'd0, -1, 1));
          else due_results.push_back(make_result(ST_FOUND, 4'(idx + 1), idx, 1));
        end
        default: begin
          if (count == 0) begin
            due_results.push_back(make_result(ST_EMPTY, 4'd0, -1, 1));
          end else begin
            for (int i = 0; i < count; i++) begin
              due_results.push_back(make_result(ST_LISTED, 4'(i + 1), i, i + 1 == count));
            end
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (due_results.size() == 0) begin
        $error("result with status %0d arrived with nothing outstanding", got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("status", 64'(want.status), 64'(got.status));
      compare("slot", 64'(want.slot), 64'(got.slot));
      compare("out_name_a", want.out_name_a, got.out_name_a);
      compare("out_name_b", want.out_name_b, got.out_name_b);
      compare("out_name_c", want.out_name_c, got.out_name_c);
      compare("out_name_d", 64'(want.out_name_d), 64'(got.out_name_d));
      compare("out_kind_a", want.out_kind_a, got.out_kind_a);
      compare("out_kind_b", want.out_kind_b, got.out_kind_b);
      compare("out_kind_c", 64'(want.out_kind_c), 64'(got.out_kind_c));
      compare("out_amount", 64'(want.out_amount), 64'(got.out_amount));
      compare("last", 64'(want.last), 64'(got.last));
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_strobe;
  out_res_t out_res;

  table_tracker         tracker = new();
  int                   sender_idle_pct;
  int                   quiet_cycles;
  bit                   activity;
  logic [NAME_BITS-1:0] name_pool [POOL_SIZE];

  compacting_keyed_list_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Results are checked before the request taken at the same edge is noted.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      activity = 0;
      if (out_strobe) begin
        tracker.check_result(out_res);
        activity = 1;
      end
      if (start && !busy) begin
        tracker.take_request(in_req);
        activity = 1;
      end
      quiet_cycles = activity ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Random text of random length; bytes after the terminating NUL hold junk if asked.
  function automatic logic [TEXT_BITS-1:0] make_text(int nbytes, bit junk);
    logic [TEXT_BITS-1:0] v;
    int                   len;
    v   = '0;
    len = ($urandom_range(0, 3) == 0) ? nbytes : $urandom_range(0, nbytes);
    for (int k = 0; k < nbytes; k++) begin
      if (k < len) v[8*k +: 8] = 8'($urandom_range(1, 255));
      else if (k > len && junk) v[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  function automatic logic [TEXT_BITS-1:0] add_junk(logic [TEXT_BITS-1:0] v, int nbytes);
    bit ended;
    ended = 0;
    for (int k = 0; k < nbytes; k++) begin
      if (ended) v[8*k +: 8] = 8'($urandom_range(0, 255));
      else if (v[8*k +: 8] == 8'h00) ended = 1;
    end
    return v;
  endfunction

  function automatic in_req_t build_request(logic [1:0] op, logic [NAME_BITS-1:0] nm,
                                            logic [KIND_BITS-1:0] kd, logic signed [31:0] amt);
    in_req_t r;
    r.req_type = op;
    r.name_a   = nm[63:0];
    r.name_b   = nm[127:64];
    r.name_c   = nm[191:128];
    r.name_d   = nm[231:192];
    r.kind_a   = kd[63:0];
    r.kind_b   = kd[127:64];
    r.kind_c   = kd[151:128];
    r.amount   = amt;
    return r;
  endfunction

  // Mostly names from a small pool so that removes and searches hit stored entries.
  function automatic in_req_t random_request();
    int                   pick;
    logic [1:0]           op;
    logic [NAME_BITS-1:0] nm;
    pick = $urandom_range(0, 99);
    op   = (pick < 40) ? REQ_INSERT : (pick < 65) ? REQ_REMOVE :
           (pick < 90) ? REQ_SEARCH : REQ_LIST;
    if ($urandom_range(0, 99) < 85) begin
      nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 1) == 1) nm = NAME_BITS'(add_junk(TEXT_BITS'(nm), NAME_BYTES));
    end else begin
      nm = NAME_BITS'(make_text(NAME_BYTES, 1'($urandom_range(0, 1))));
    end
    return build_request(op, nm, KIND_BITS'(make_text(KIND_BYTES, 1'($urandom_range(0, 1)))),
                         $urandom());
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue(in_req_t r);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
  endtask

  initial begin
    logic [NAME_BITS-1:0] nm_full;
    logic [NAME_BITS-1:0] nm_short;
    logic [NAME_BITS-1:0] nm_absent;
    logic [KIND_BITS-1:0] kd_none;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req          = '0;
    sender_idle_pct = 8;
    for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = NAME_BITS'(make_text(NAME_BYTES, 0));
    nm_full   = '1;
    nm_short  = NAME_BITS'(16'h6261);
    nm_absent = NAME_BITS'(make_text(NAME_BYTES, 0));
    nm_absent[7:0] = 8'h01;
    kd_none   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Requests on an empty table.
    issue(build_request(REQ_LIST, nm_full, kd_none, 0));
    issue(build_request(REQ_REMOVE, nm_full, kd_none, 0));
    issue(build_request(REQ_SEARCH, nm_full, kd_none, 0));
    // Fill to capacity with extreme contents first.
    issue(build_request(REQ_INSERT, nm_full, '1, 32'sh7fffffff));
    issue(build_request(REQ_INSERT, '0, kd_none, 32'sh80000000));
    issue(build_request(REQ_INSERT, NAME_BITS'(add_junk(TEXT_BITS'(nm_short), NAME_BYTES)),
                        KIND_BITS'(add_junk(TEXT_BITS'(24'h00_0078), KIND_BYTES)), -1));
    for (int i = 3; i < DEPTH; i++) begin
      issue(build_request(REQ_INSERT, name_pool[i],
                          KIND_BITS'(make_text(KIND_BYTES, 1)), $urandom()));
    end
    issue(build_request(REQ_INSERT, nm_absent, kd_none, 5));
    issue(build_request(REQ_LIST, '0, kd_none, 0));
    issue(build_request(REQ_SEARCH, name_pool[DEPTH-1], kd_none, 0));
    // A different tail after the NUL must still match the stored name.
    issue(build_request(REQ_SEARCH, NAME_BITS'(add_junk(TEXT_BITS'(nm_short), NAME_BYTES)),
                        kd_none, 0));
    issue(build_request(REQ_REMOVE, NAME_BITS'(add_junk(TEXT_BITS'(nm_short), NAME_BYTES)),
                        kd_none, 0));
    issue(build_request(REQ_REMOVE, nm_absent, kd_none, 0));
    issue(build_request(REQ_SEARCH, nm_absent, kd_none, 0));
    issue(build_request(REQ_REMOVE, nm_full, kd_none, 0));
    issue(build_request(REQ_REMOVE, name_pool[DEPTH-1], kd_none, 0));
    issue(build_request(REQ_LIST, '0, kd_none, 0));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 83 : 0;
      for (int n = 0; n < 119; n++) issue(random_request());
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### compacting_keyed_list_core.f
rtl/ckl_pkg.sv
rtl/ckl_cell.sv
rtl/compacting_keyed_list_core.sv
rtl/ckl_checker.sv
tb/compacting_keyed_list_core_tb.sv
